[hdl/dscq_pkg.sv]
// Shared types and constants for the DPCM subband codebook quantizer.
`timescale 1ns / 1ps
package dscq_pkg;

    // Item kinds carried in the input tuser field
    localparam logic [1:0] ACT_LOAD_AVG = 2'd0;
    localparam logic [1:0] ACT_LOAD_DIF = 2'd1;
    localparam logic [1:0] ACT_ENCODE   = 2'd2;

    // Arithmetic widths
    localparam int ENTRY_W = 10;
    localparam int VAL_W   = 14;  // residual and compare width
    localparam int RECON_W = 12;

    // One queued item, already classified by the front end
    typedef struct packed {
        logic [1:0]         action;
        logic [7:0]         entry_index;
        logic [ENTRY_W-1:0] entry_value;
        logic [7:0]         avg_sample;
        logic [7:0]         diff_sample;
        logic               row_start;
        logic               frame_start;
    } item_t;

endpackage

[hdl/dscq_front.sv]
// Front end: accepts input transfers, drops undefined actions, two-entry queue.
`timescale 1ns / 1ps
module dscq_front
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  dscq_pkg::item_t in_item,
    output logic           q_valid,
    output dscq_pkg::item_t q_item,
    input  logic           q_pop
);

    dscq_pkg::item_t slot_reg [2];
    logic [1:0] count_reg, count_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic       wr_ptr_reg, wr_ptr_next;
    logic       push;
    logic       keep;
    logic       do_pop;

    // Undefined action codes are consumed without entering the queue
    assign keep     = (in_item.action == dscq_pkg::ACT_LOAD_AVG) ||
                      (in_item.action == dscq_pkg::ACT_LOAD_DIF) ||
                      (in_item.action == dscq_pkg::ACT_ENCODE);
    assign in_ready = (count_reg != 2'd2);
    assign push     = in_valid && in_ready && keep;
    assign q_valid  = (count_reg != 2'd0);
    assign q_item   = slot_reg[rd_ptr_reg];
    assign do_pop   = q_pop && q_valid;

    // Pointer and fill count
    always_comb
    begin
        count_next  = count_reg;
        rd_ptr_next = rd_ptr_reg;
        wr_ptr_next = wr_ptr_reg;
        if (push)
        begin
            wr_ptr_next = ~wr_ptr_reg;
        end
        if (do_pop)
        begin
            rd_ptr_next = ~rd_ptr_reg;
        end
        if (push && !do_pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (!push && do_pop)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= 2'd0;
            rd_ptr_reg <= 1'b0;
            wr_ptr_reg <= 1'b0;
        end
        else
        begin
            count_reg  <= count_next;
            rd_ptr_reg <= rd_ptr_next;
            wr_ptr_reg <= wr_ptr_next;
        end
    end

    // Queue storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= in_item;
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == 2'd2) |-> !push)
        else $error("queue push while full");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == 2'd0) |=> (count_reg != 2'd3))
        else $error("queue count out of range");
    a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (q_pop && !q_valid) |=> (count_reg == $past(count_reg) ||
                                 count_reg == $past(count_reg) + 2'd1))
        else $error("pop on empty queue changed count");
`endif

endmodule

[hdl/dscq_back.sv]
// Back end: codebook memories, codebook scan, prediction state, result register.
`timescale 1ns / 1ps
module dscq_back
#(
    parameter int AW = 8
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic [AW:0]     book_n,
    input  logic            q_valid,
    input  dscq_pkg::item_t q_item,
    output logic            q_pop,
    output logic            out_valid,
    input  logic            out_ready,
    output logic [7:0]      out_avg_index,
    output logic [7:0]      out_diff_index,
    output logic [11:0]     out_recon
);

    localparam int DEPTH = 1 << AW;
    localparam int VW    = dscq_pkg::VAL_W;
    localparam int EW    = dscq_pkg::ENTRY_W;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_PREP  = 5'b00010,
        S_SCAN  = 5'b00100,
        S_RECON = 5'b01000,
        S_RWAIT = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    logic [EW-1:0] avg_mem [DEPTH];
    logic [EW-1:0] dif_mem [DEPTH];
    logic [EW-1:0] avg_rd_reg, dif_rd_reg;
    logic [AW-1:0] rd_addr;
    logic [AW-1:0] wr_addr;
    logic          pos_ok;
    logic          wr_avg, wr_dif;

    dscq_pkg::item_t item_reg;
    logic signed [11:0] row_pred_reg, row_pred_next;
    logic signed [11:0] cz_pred_reg, cz_pred_next;
    logic signed [11:0] pred;
    logic signed [VW-1:0] va_reg, vd_reg;
    logic [AW:0]     cnt_reg, cnt_next;
    logic signed [VW-1:0] a_prev_reg, d_prev_reg;
    logic signed [VW-1:0] a_first_reg, d_first_reg;
    logic            a_done_reg, a_done_next, d_done_reg, d_done_next;
    logic [AW-1:0]   ai_reg, ai_next, di_reg, di_next;
    logic signed [VW-1:0] a_cur, d_cur;
    logic [AW-1:0]   lo_idx, hi_idx, last_idx;
    logic            at_end;
    logic            a_hit, a_hi, d_hit, d_hi;
    logic signed [12:0] sum13;
    logic signed [11:0] recon;
    logic            out_free;
    logic            out_load;
    logic            out_valid_reg;
    logic [7:0]      oai_reg, odi_reg;
    logic [11:0]     orec_reg;

    // Bracket test: hit when a <= v <= b, hi when the upper entry is chosen
    function automatic logic [1:0] bracket(input logic signed [VW-1:0] a,
                                           input logic signed [VW-1:0] b,
                                           input logic signed [VW-1:0] v);
        logic hit;
        logic hi;
        hit = (a <= v) && (v <= b);
        hi  = !((b - v) > (v - a));
        return {hit, hi};
    endfunction

    // Load decode
    assign wr_addr = AW'(q_item.entry_index);
    assign pos_ok  = ((AW + 9)'(q_item.entry_index) < (AW + 9)'(DEPTH));
    assign q_pop   = (state_reg == S_IDLE) && q_valid;
    assign wr_avg  = q_pop && pos_ok && (q_item.action == dscq_pkg::ACT_LOAD_AVG);
    assign wr_dif  = q_pop && pos_ok && (q_item.action == dscq_pkg::ACT_LOAD_DIF);

    // Read address: start of scan, next scan entry, or chosen average entry
    // (held while the result waits for the output register)
    always_comb
    begin
        unique case (state_reg)
            S_SCAN:          rd_addr = cnt_reg[AW-1:0];
            S_RECON, S_RWAIT: rd_addr = ai_reg;
            default:         rd_addr = '0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_avg)
        begin
            avg_mem[wr_addr] <= q_item.entry_value;
        end
        avg_rd_reg <= avg_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (wr_dif)
        begin
            dif_mem[wr_addr] <= q_item.entry_value;
        end
        dif_rd_reg <= dif_mem[rd_addr];
    end

    // Scan compare on the entry that arrived this cycle
    assign a_cur    = VW'($signed(avg_rd_reg));
    assign d_cur    = VW'($signed(dif_rd_reg));
    assign hi_idx   = AW'(cnt_reg - (AW + 1)'(1));
    assign lo_idx   = AW'(cnt_reg - (AW + 1)'(2));
    assign last_idx = AW'(book_n - (AW + 1)'(1));
    assign at_end   = (cnt_reg == book_n);
    assign {a_hit, a_hi} = bracket(a_prev_reg, a_cur, va_reg);
    assign {d_hit, d_hi} = bracket(d_prev_reg, d_cur, vd_reg);

    assign pred = item_reg.row_start ? cz_pred_reg : row_pred_reg;

    // Reconstruction with saturation; a frame start passes the average sample through
    always_comb
    begin
        sum13 = {pred[11], pred} + 13'($signed(avg_rd_reg));
        if (item_reg.frame_start)
        begin
            recon = {4'b0, item_reg.avg_sample};
        end
        else if (sum13[12] != sum13[11])
        begin
            recon = sum13[12] ? 12'sh800 : 12'sh7FF;
        end
        else
        begin
            recon = sum13[11:0];
        end
    end

    assign out_free = !out_valid_reg || out_ready;
    assign out_load = (state_reg == S_RWAIT) && out_free;

    // Control sequence
    always_comb
    begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        a_done_next   = a_done_reg;
        d_done_next   = d_done_reg;
        ai_next       = ai_reg;
        di_next       = di_reg;
        row_pred_next = row_pred_reg;
        cz_pred_next  = cz_pred_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (q_valid && (q_item.action == dscq_pkg::ACT_ENCODE))
                begin
                    state_next = S_PREP;
                end
            end
            S_PREP:
            begin
                cnt_next    = (AW + 1)'(1);
                a_done_next = 1'b0;
                d_done_next = 1'b0;
                state_next  = S_SCAN;
            end
            S_SCAN:
            begin
                if (cnt_reg != (AW + 1)'(1))
                begin
                    if (!a_done_reg && a_hit)
                    begin
                        a_done_next = 1'b1;
                        ai_next     = a_hi ? hi_idx : lo_idx;
                    end
                    if (!d_done_reg && d_hit)
                    begin
                        d_done_next = 1'b1;
                        di_next     = d_hi ? hi_idx : lo_idx;
                    end
                end
                if (at_end)
                begin
                    if (!a_done_next)
                    begin
                        ai_next = (va_reg < a_first_reg) ? '0 : last_idx;
                    end
                    if (!d_done_next)
                    begin
                        di_next = (vd_reg < d_first_reg) ? '0 : last_idx;
                    end
                    state_next = S_RECON;
                end
                else if (a_done_next && d_done_next)
                begin
                    state_next = S_RECON;
                end
                cnt_next = cnt_reg + (AW + 1)'(1);
            end
            S_RECON:
            begin
                state_next = S_RWAIT;
            end
            S_RWAIT:
            begin
                if (out_free)
                begin
                    row_pred_next = recon;
                    if (item_reg.row_start || item_reg.frame_start)
                    begin
                        cz_pred_next = recon;
                    end
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            a_done_reg    <= 1'b0;
            d_done_reg    <= 1'b0;
            row_pred_reg  <= '0;
            cz_pred_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            a_done_reg   <= a_done_next;
            d_done_reg   <= d_done_next;
            row_pred_reg <= row_pred_next;
            cz_pred_reg  <= cz_pred_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        ai_reg <= ai_next;
        di_reg <= di_next;
        if (q_pop)
        begin
            item_reg <= q_item;
        end
        if (state_reg == S_PREP)
        begin
            va_reg <= item_reg.frame_start ? VW'({1'b0, item_reg.avg_sample}) :
                      VW'({1'b0, item_reg.avg_sample}) - VW'(pred);
            vd_reg <= VW'($signed(item_reg.diff_sample));
        end
        if (state_reg == S_SCAN)
        begin
            a_prev_reg <= a_cur;
            d_prev_reg <= d_cur;
            if (cnt_reg == (AW + 1)'(1))
            begin
                a_first_reg <= a_cur;
                d_first_reg <= d_cur;
            end
        end
        if (out_load)
        begin
            oai_reg  <= 8'(ai_reg);
            odi_reg  <= 8'(di_reg);
            orec_reg <= recon;
        end
    end

    assign out_valid      = out_valid_reg;
    assign out_avg_index  = oai_reg;
    assign out_diff_index = odi_reg;
    assign out_recon      = orec_reg;

`ifndef SYNTHESIS
    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> (state_reg == S_IDLE))
        else $error("queue popped outside idle");
    a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RECON) |-> ((AW + 1)'(ai_reg) < book_n &&
                                    (AW + 1)'(di_reg) < book_n))
        else $error("chosen index beyond codebook size");
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_RWAIT))
        else $error("result loaded outside reconstruction step");
    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> (cnt_reg <= book_n))
        else $error("scan ran past codebook end");
`endif

endmodule

[hdl/dpcm_subband_codebook_quantizer_unit.sv]
// Top level of the DPCM subband codebook quantizer.
// Sequence: the back end takes load items while idle; an encode item goes through
//   prepare, a scan of 2..2^(clamped code_bits) entries, reconstruct, output wait.
// Throughput: one item at a time; the linear codebook scan over one memory read
//   port per codebook sets the rate. Input and output are decoupled by a queue.
// Reset: rst_n asynchronous, active low; clears predictions, sets code_bits to 8.
`timescale 1ns / 1ps
module dpcm_subband_codebook_quantizer_unit
#(
    parameter int MAX_CODE_BITS = 8
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [3:0]  cfg_data,       // code_bits
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // entry_index[7:0], entry_value[17:8], avg_sample[25:18], diff_sample[33:26],
    // row_start[34], frame_start[35], zero[39:36]
    input  logic [39:0] s_axis_tdata,
    input  logic [1:0]  s_axis_tuser,   // action[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // avg_index[7:0], diff_index[15:8], recon_value[27:16], zero[31:28]
    output logic [31:0] m_axis_tdata
);

    localparam int AW = MAX_CODE_BITS;

    logic [3:0]      code_bits_reg;
    logic [3:0]      eff_bits;
    logic [AW:0]     book_n;
    dscq_pkg::item_t in_item;
    dscq_pkg::item_t q_item;
    logic            q_valid;
    logic            q_pop;
    logic [7:0]      o_ai, o_di;
    logic [11:0]     o_rec;

    // Configuration register
    assign cfg_ready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            code_bits_reg <= 4'd8;
        end
        else if (cfg_valid)
        begin
            code_bits_reg <= cfg_data;
        end
    end

    // Clamp code width to 1..MAX_CODE_BITS
    always_comb
    begin
        priority if (code_bits_reg == 4'd0)
        begin
            eff_bits = 4'd1;
        end
        else if (32'(code_bits_reg) > MAX_CODE_BITS)
        begin
            eff_bits = 4'(MAX_CODE_BITS);
        end
        else
        begin
            eff_bits = code_bits_reg;
        end
    end
    assign book_n = (AW + 1)'(1) << eff_bits;

    // Unpack input
    assign in_item.action      = s_axis_tuser;
    assign in_item.entry_index = s_axis_tdata[7:0];
    assign in_item.entry_value = s_axis_tdata[17:8];
    assign in_item.avg_sample  = s_axis_tdata[25:18];
    assign in_item.diff_sample = s_axis_tdata[33:26];
    assign in_item.row_start   = s_axis_tdata[34];
    assign in_item.frame_start = s_axis_tdata[35];

    dscq_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_item  (in_item),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop)
    );

    dscq_back #(.AW(AW)) u_back
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .book_n         (book_n),
        .q_valid        (q_valid),
        .q_item         (q_item),
        .q_pop          (q_pop),
        .out_valid      (m_axis_tvalid),
        .out_ready      (m_axis_tready),
        .out_avg_index  (o_ai),
        .out_diff_index (o_di),
        .out_recon      (o_rec)
    );

    assign m_axis_tdata = {4'b0, o_rec, o_di, o_ai};

endmodule

[dv/tb_dpcm_subband_codebook_quantizer_unit.sv]
// Testbench for the DPCM subband codebook quantizer: directed table plus random traffic.
`timescale 1ns / 1ps
module tb_dpcm_subband_codebook_quantizer_unit;

    localparam int DEPTH      = 256;
    localparam int IDLE_LIMIT = 20000;
    localparam int N_RANDOM   = 660;

    // Undefined action code, dropped by the block
    localparam logic [1:0] ACT_RESERVED = 2'd3;

    typedef struct packed {
        logic [7:0]  avg_index;
        logic [7:0]  diff_index;
        logic [11:0] recon_value;
    } code_t;

    // One row of the directed table; check_fixed marks a typed-in expectation
    typedef struct {
        logic [1:0] action;
        logic [7:0] entry_index;
        logic [9:0] entry_value;
        logic [7:0] avg_sample;
        logic [7:0] diff_sample;
        logic       row_start;
        logic       frame_start;
        bit         check_fixed;
        code_t      fixed_code;
    } row_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [3:0]  cfg_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata;
    logic [1:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;

    // Predictor state
    int    avg_book [DEPTH];
    int    dif_book [DEPTH];
    int    row_pred;
    int    col0_pred;
    int    width_sel;

    code_t expected_codes [$];
    int    mismatches;
    int    idle_cycles;
    bit    sink_hold;
    bit    sink_no_idle;
    bit    src_no_idle;

    dpcm_subband_codebook_quantizer_unit dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic int book_entries();
        int b;
        b = width_sel;
        if (b < 1) b = 1;
        if (b > 8) b = 8;
        return 1 << b;
    endfunction

    // Nearest entry, tie to the higher one; below the first entry gives 0
    function automatic int nearest_entry(bit use_avg, int v);
        int n;
        int a;
        int b;
        n = book_entries();
        for (int l = 0; l + 1 < n; l++)
        begin
            a = use_avg ? avg_book[l] : dif_book[l];
            b = use_avg ? avg_book[l+1] : dif_book[l+1];
            if (a <= v && v <= b)
                return ((b - v) > (v - a)) ? l : l + 1;
        end
        a = use_avg ? avg_book[0] : dif_book[0];
        if (v < a)
            return 0;
        return n - 1;
    endfunction

    // Advance predictor state for one item; returns 1 if a code word results
    function automatic bit encode_item(logic [1:0] act, logic [7:0] pos, logic [9:0] val,
                                       logic [7:0] avg, logic [7:0] dif, logic rs,
                                       logic fs, output code_t code);
        int ai;
        int di;
        int recon;
        int pred;
        code = '0;
        if (act == dscq_pkg::ACT_LOAD_AVG)
        begin
            avg_book[pos] = $signed(val);
            return 1'b0;
        end
        if (act == dscq_pkg::ACT_LOAD_DIF)
        begin
            dif_book[pos] = $signed(val);
            return 1'b0;
        end
        if (act != dscq_pkg::ACT_ENCODE)
            return 1'b0;
        if (fs)
        begin
            ai = nearest_entry(1'b1, int'(avg));
            recon = int'(avg);
        end
        else
        begin
            pred = rs ? col0_pred : row_pred;
            ai = nearest_entry(1'b1, int'(avg) - pred);
            recon = pred + avg_book[ai];
            if (recon > 2047) recon = 2047;
            if (recon < -2048) recon = -2048;
        end
        di = nearest_entry(1'b0, $signed(dif));
        row_pred = recon;
        if (fs || rs)
            col0_pred = recon;
        code.avg_index   = ai[7:0];
        code.diff_index  = di[7:0];
        code.recon_value = recon[11:0];
        return 1'b1;
    endfunction

    // Offer one item; waits for its transfer
    task automatic send_item(logic [1:0] act, logic [7:0] pos, logic [9:0] val,
                             logic [7:0] avg, logic [7:0] dif, logic rs, logic fs,
                             bit check_fixed, code_t fixed_code);
        code_t code;
        bit has_code;
        while (!src_no_idle && $urandom_range(99) < 35)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= act;
        s_axis_tdata  <= {4'b0, fs, rs, dif, avg, val, pos};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        has_code = encode_item(act, pos, val, avg, dif, rs, fs, code);
        if (has_code)
        begin
            if (check_fixed && code != fixed_code)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("table row expectation %h differs from predictor %h",
                             fixed_code, code);
            end
            if (check_fixed)
                code = fixed_code;
            expected_codes = {expected_codes, code};
        end
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (expected_codes.size() != 0)
            @(posedge clk);
        // loads may still be in flight behind the last result
        repeat (40) @(posedge clk);
    endtask

    task automatic write_width(logic [3:0] w);
        cfg_valid <= 1'b1;
        cfg_data  <= w;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        width_sel = w;
    endtask

    // Sorted book filling the active depth; wide books span -512..511 evenly, others random spacing, random start
    task automatic load_books(bit wide);
        int n;
        int base;
        int v;
        n = book_entries();
        for (int k = 0; k < 2; k++)
        begin
            base = wide ? -512 : -$urandom_range(300, 0);
            for (int i = 0; i < n; i++)
            begin
                v = base + i * (wide ? (1023 / (n > 1 ? n - 1 : 1)) : $urandom_range(4, 1));
                if (v > 511) v = 511;
                if (i == n - 1 && wide) v = 511;
                send_item(k == 0 ? dscq_pkg::ACT_LOAD_AVG : dscq_pkg::ACT_LOAD_DIF,
                          i[7:0], v[9:0], 8'd0, 8'd0, 1'b0, 1'b0, 1'b0, '0);
            end
        end
    endtask

    task automatic random_encode();
        int pick;
        logic [1:0] act;
        pick = $urandom_range(99);
        act = dscq_pkg::ACT_ENCODE;
        if (pick < 3)
            act = ACT_RESERVED;
        send_item(act, 8'($urandom), 10'($urandom), 8'($urandom), 8'($urandom),
                  1'($urandom_range(99) < 15), 1'($urandom_range(99) < 5),
                  1'b0, '0);
    endtask

    // Result side: random stalls, one long hold-off, field check
    always @(posedge clk or negedge rst_n)
    begin
        code_t got;
        code_t want;
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.avg_index   = m_axis_tdata[7:0];
                got.diff_index  = m_axis_tdata[15:8];
                got.recon_value = m_axis_tdata[27:16];
                if (expected_codes.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected code word %h", got);
                end
                else
                begin
                    want = expected_codes.pop_front();
                    if (got != want || m_axis_tdata[31:28] != 4'b0)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("code word mismatch: ",
                                     "avg_index exp %0d got %0d, ",
                                     want.avg_index, got.avg_index,
                                     "diff_index exp %0d got %0d, ",
                                     want.diff_index, got.diff_index,
                                     "recon exp %0d got %0d",
                                     $signed(want.recon_value),
                                     $signed(got.recon_value));
                    end
                end
            end
            m_axis_tready <= !sink_hold && (sink_no_idle || $urandom_range(99) >= 35);
        end
    end

    // Watchdog on cycles with no transfer
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    // Long receiver hold-off, counted here
    task automatic hold_sink(int cycles);
        sink_hold = 1'b1;
        repeat (cycles) @(posedge clk);
        sink_hold = 1'b0;
    endtask

    initial
    begin
        row_t rows [$];
        row_t r;
        int widths [6];
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = '0;
        mismatches = 0;
        idle_cycles = 0;
        sink_hold = 1'b0;
        sink_no_idle = 1'b0;
        src_no_idle = 1'b0;
        row_pred = 0;
        col0_pred = 0;
        width_sel = 8;
        foreach (avg_book[i])
        begin
            avg_book[i] = 0;
            dif_book[i] = 0;
        end
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: code width 1, two-entry books {-512, 511}
        write_width(4'd1);
        r = '{dscq_pkg::ACT_LOAD_AVG, 8'd0, 10'h200, 8'd0, 8'd0, 1'b0, 1'b0, 1'b0, '0};
        rows = {rows, r};
        r.entry_index = 8'd1; r.entry_value = 10'h1FF; rows = {rows, r};
        r.action = dscq_pkg::ACT_LOAD_DIF; r.entry_index = 8'd0; r.entry_value = 10'h200;
        rows = {rows, r};
        r.entry_index = 8'd1; r.entry_value = 10'h1FF; rows = {rows, r};
        // load outside the active part of a narrow book, and an undefined action
        r.entry_index = 8'd255; r.entry_value = 10'h000; rows = {rows, r};
        r.action = ACT_RESERVED; rows = {rows, r};
        // frame start, avg 255, diff -128: recon 255, avg idx 1, diff idx 0
        r = '{dscq_pkg::ACT_ENCODE, 8'd0, 10'd0, 8'd255, 8'h80, 1'b0, 1'b1, 1'b1,
              '{8'd1, 8'd0, 12'd255}};
        rows = {rows, r};
        // both flags, avg 0, diff 127: frame wins, recon 0
        r = '{dscq_pkg::ACT_ENCODE, 8'd0, 10'd0, 8'd0, 8'h7F, 1'b1, 1'b1, 1'b1,
              '{8'd1, 8'd1, 12'd0}};
        rows = {rows, r};
        // row continues, then a row start; codes come from the predictor model
        r = '{dscq_pkg::ACT_ENCODE, 8'd0, 10'd0, 8'd0, 8'h00, 1'b0, 1'b0, 1'b0, '0};
        rows = {rows, r};
        r.avg_sample = 8'd255; rows = {rows, r};
        r.avg_sample = 8'd255; rows = {rows, r};
        r.avg_sample = 8'd255; rows = {rows, r};
        r.avg_sample = 8'd255; rows = {rows, r};
        r.avg_sample = 8'd0; r.row_start = 1'b1; rows = {rows, r};
        r.row_start = 1'b0; rows = {rows, r};
        rows = {rows, r};
        rows = {rows, r};
        rows = {rows, r};
        rows = {rows, r};
        foreach (rows[i])
            send_item(rows[i].action, rows[i].entry_index, rows[i].entry_value,
                      rows[i].avg_sample, rows[i].diff_sample, rows[i].row_start,
                      rows[i].frame_start, rows[i].check_fixed, rows[i].fixed_code);

        // Random phases across code widths, extremes included
        widths = '{8, 0, 3, 15, 5, 2};
        for (int p = 0; p < 6; p++)
        begin
            drain_results();
            write_width(4'(widths[p]));
            load_books(p % 2 == 0);
            src_no_idle = (p == 4);
            sink_no_idle = (p == 4);
            if (p == 2)
                fork
                    hold_sink(600);
                join_none
            for (int i = 0; i < N_RANDOM / 6; i++)
                random_encode();
        end
        src_no_idle = 1'b0;
        sink_no_idle = 1'b0;

        drain_results();
        if (mismatches == 0 && expected_codes.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
